// ===== hw/rtl/arqsw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window ARQ sender.
package arqsw_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_END     = 3'd2,
    ACT_TAKEN   = 3'd3,
    ACT_IGNORED = 3'd4,
    ACT_TIMEOUT = 3'd5,
    ACT_QUIET   = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_SEND   = 3'd2,
    OP_ACK    = 3'd3,
    OP_AGE    = 3'd4,
    OP_REWIND = 3'd5,
    OP_SCAN   = 3'd6,
    OP_SWEEP  = 3'd7
  } cell_op_t;

  typedef enum logic [1:0] {
    TOK_HOLD  = 2'd0,
    TOK_CLR   = 2'd1,
    TOK_LOAD  = 2'd2,
    TOK_SHIFT = 2'd3
  } tok_op_t;

  typedef struct packed {
    cell_op_t    op;
    tok_op_t     tok;
    logic        clr_cached;
    logic [7:0]  limit;
  } cell_ctl_t;

  typedef struct packed {
    logic        ack;
    logic        cached;
    logic [7:0]  timer;
    logic        pass;
    logic        expire;
  } cell_stat_t;

  localparam logic [1:0]  REG_MODE  = 2'd0;
  localparam logic [1:0]  REG_TOTAL = 2'd1;
  localparam logic [1:0]  REG_LIMIT = 2'd2;

  localparam logic [7:0]  TIMER_MAX = 8'hFF;
  localparam logic [7:0]  LIMIT_RST = 8'd5;
  localparam logic [15:0] TOTAL_RST = 16'd1;
  localparam logic [15:0] CNT_MAX16 = 16'hFFFF;

endpackage

// ===== hw/rtl/arqsw_cell.sv =====
`timescale 1ns / 1ps
// One window entry: ack flag, cached flag, retransmit timer and the scan token.
module arqsw_cell import arqsw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic       tgt,
  input  logic       ld,
  input  logic       in_win,
  input  logic       rd,
  input  logic       tok_in,
  output logic       tok_o,
  output cell_stat_t stat
);

  logic       ack_r, ack_nxt;
  logic       cached_r, cached_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic       tok_r, tok_nxt;
  logic [8:0] t_inc;
  logic       t_exp;
  logic [7:0] t_sat;

  assign t_inc = {1'b0, timer_r} + 9'd1;
  assign t_exp = t_inc > {1'b0, ctl.limit};
  assign t_sat = t_inc[8] ? TIMER_MAX : t_inc[7:0];

  assign tok_o       = tok_r;
  assign stat.ack    = rd & ack_r;
  assign stat.cached = rd & cached_r;
  assign stat.timer  = {8{rd}} & timer_r;
  assign stat.pass   = tok_r & cached_r & ack_r;
  assign stat.expire = tok_r & ~ack_r & t_exp;

  always_comb begin
    ack_nxt    = ack_r;
    cached_nxt = cached_r;
    timer_nxt  = timer_r;
    case (ctl.op)
      OP_CLEAR: begin
        ack_nxt    = 1'b1;
        cached_nxt = 1'b0;
        timer_nxt  = '0;
      end
      OP_SEND: begin
        if (tgt) begin
          ack_nxt    = 1'b0;
          cached_nxt = 1'b1;
        end
      end
      OP_ACK: begin
        if (tgt) begin
          ack_nxt   = 1'b1;
          timer_nxt = '0;
          if (ctl.clr_cached) cached_nxt = 1'b0;
        end
      end
      OP_AGE: begin
        if (tgt) timer_nxt = t_exp ? 8'd0 : t_sat;
      end
      OP_REWIND: begin
        if (tgt) timer_nxt = '0;
        if (in_win) ack_nxt = 1'b1;
      end
      OP_SCAN: begin
        if (tok_r && cached_r && ack_r) cached_nxt = 1'b0;
      end
      OP_SWEEP: begin
        if (tok_r && !ack_r) begin
          if (t_exp) begin
            timer_nxt = '0;
            ack_nxt   = 1'b1;
          end else begin
            timer_nxt = t_sat;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (ctl.tok)
      TOK_CLR:   tok_nxt = 1'b0;
      TOK_LOAD:  tok_nxt = ld;
      TOK_SHIFT: tok_nxt = tok_in;
      default:   tok_nxt = tok_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_r    <= 1'b1;
      cached_r <= 1'b0;
      timer_r  <= '0;
      tok_r    <= 1'b0;
    end else begin
      ack_r    <= ack_nxt;
      cached_r <= cached_nxt;
      timer_r  <= timer_nxt;
      tok_r    <= tok_nxt;
    end
  end

endmodule

// ===== hw/rtl/arq_sliding_window_sender.sv =====
`timescale 1ns / 1ps
// Top level: sliding-window ARQ sender with a ring of per-entry cells.
// Input channel (in_valid/in_ready) carries one command: start, try-send,
// ack or tick. Each accepted transaction produces exactly one result
// transaction on out_valid/out_ready, in order.
// The user must write configuration over the APB-style port only while the
// block is idle; the block does not enforce this. Register 0 is timeout
// mode, 1 total packets, 2 timeout limit. Start, try-send, Go-Back-N ack,
// ack of a non-base entry and Go-Back-N tick pass through an execute state
// and a done state, where the result is registered before the block idles.
// A Selective-Repeat ack at the base moves a token along the cell ring, one
// entry per cycle, in a scan state, for each extra entry the base advances.
// A Selective-Repeat tick sweeps the token over all cells in a sweep state.
// One command is in flight at a time; the output register holds a finished
// result while the next command is already being processed.
// If the receiver stalls, the block holds its next result until the output
// register frees, and stops taking commands.
// Reset empties the window (all entries acked, not cached, timers zero),
// clears counters and loads mode 0, total 1, limit 5.
module arq_sliding_window_sender import arqsw_pkg::*; #(
  parameter int SEQ_COUNT = 20,
  parameter int WINDOW    = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_ack_kind,
  input  logic [7:0]  in_ack_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [4:0]  out_send_seq,
  output logic [15:0] out_packet_index,
  output logic        out_new_packet,
  output logic [4:0]  out_base_seq,
  output logic [15:0] out_acked_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SEQ_W   = (SEQ_COUNT > 2) ? $clog2(SEQ_COUNT) : 1;
  localparam int CNT_TOP = (SEQ_COUNT > WINDOW) ? SEQ_COUNT : WINDOW;
  localparam int CNT_W   = $clog2(CNT_TOP + 1);
  localparam logic [8:0]       WIN9    = 9'(WINDOW);
  localparam logic [8:0]       SEQ9    = 9'(SEQ_COUNT);
  localparam logic [SEQ_W-1:0] SEQ_END = SEQ_W'(SEQ_COUNT - 1);
  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] SWP_END = CNT_W'(SEQ_COUNT - 1);
  localparam logic [15:0]      WIN16   = 16'(WINDOW);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  function automatic logic [SEQ_W-1:0] offs(input logic [SEQ_W-1:0] x,
                                            input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] d;
    d = {1'b0, x} - {1'b0, b};
    if (x < b) d = d + (SEQ_W + 1)'(SEQ_COUNT);
    return d[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] inc(input logic [SEQ_W-1:0] x);
    return (x == SEQ_END) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [4:0] to5(input logic [SEQ_W-1:0] x);
    logic [SEQ_W+4:0] w;
    w = (SEQ_W + 5)'(x);
    return w[4:0];
  endfunction

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic [15:0]       total_r;
  logic [7:0]        limit_r;
  cmd_t              cmd_r;
  logic              kind_r;
  logic [7:0]        aseq_r;
  logic [SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]  base_r, base_nxt;
  logic [15:0]       sent_r, sent_nxt;
  logic [15:0]       acked_r, acked_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  action_t           act_r, act_nxt;
  logic [4:0]        sseq_r, sseq_nxt;
  logic [15:0]       pidx_r, pidx_nxt;
  logic              fresh_r, fresh_nxt;
  logic              out_valid_r;
  logic [2:0]        o_act_r;
  logic [4:0]        o_sseq_r;
  logic [15:0]       o_pidx_r;
  logic              o_fresh_r;
  logic [4:0]        o_base_r;
  logic [15:0]       o_acked_r;

  cell_ctl_t               ctl;
  logic [SEQ_W-1:0]        tgt_idx, ld_idx, rd_idx;
  logic [SEQ_COUNT-1:0]    tgt_v, ld_v, win_v, rd_v, tok_v;
  cell_stat_t [SEQ_COUNT-1:0] stat_v;
  logic                    rd_ack, rd_cached, any_pass, any_exp;
  logic [7:0]              rd_timer;

  logic                    in_fire, cfg_wr, out_load;
  logic [SEQ_W-1:0]        aseq_idx, base_inc;
  logic                    aseq_ok, next_in_win, gbn_exp;
  logic [15:0]             acked_inc, sent_inc, sent_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign out_action       = o_act_r;
  assign out_send_seq     = o_sseq_r;
  assign out_packet_index = o_pidx_r;
  assign out_new_packet   = o_fresh_r;
  assign out_base_seq     = o_base_r;
  assign out_acked_total  = o_acked_r;

  assign aseq_idx    = aseq_r[SEQ_W-1:0];
  assign aseq_ok     = ({1'b0, aseq_r} < SEQ9) && (9'(offs(aseq_idx, base_r)) < WIN9);
  assign next_in_win = 9'(offs(next_seq_r, base_r)) < WIN9;
  assign gbn_exp     = ({1'b0, rd_timer} + 9'd1) > {1'b0, limit_r};
  assign base_inc    = inc(base_r);
  assign acked_inc   = (acked_r == CNT_MAX16) ? acked_r : acked_r + 16'd1;
  assign sent_inc    = (sent_r == CNT_MAX16) ? sent_r : sent_r + 16'd1;
  assign sent_dec    = (sent_r == 16'd0) ? sent_r : sent_r - 16'd1;

  for (genvar g = 0; g < SEQ_COUNT; g++) begin : g_cell
    localparam logic [SEQ_W-1:0] IDX = SEQ_W'(g);
    assign tgt_v[g] = (tgt_idx == IDX);
    assign ld_v[g]  = (ld_idx == IDX);
    assign rd_v[g]  = (rd_idx == IDX);
    assign win_v[g] = 9'(offs(IDX, base_r)) < WIN9;
    arqsw_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .tgt    (tgt_v[g]),
      .ld     (ld_v[g]),
      .in_win (win_v[g]),
      .rd     (rd_v[g]),
      .tok_in (tok_v[(g + SEQ_COUNT - 1) % SEQ_COUNT]),
      .tok_o  (tok_v[g]),
      .stat   (stat_v[g])
    );
  end

  always_comb begin
    rd_ack    = 1'b0;
    rd_cached = 1'b0;
    rd_timer  = '0;
    any_pass  = 1'b0;
    any_exp   = 1'b0;
    for (int i = 0; i < SEQ_COUNT; i++) begin
      rd_ack    = rd_ack | stat_v[i].ack;
      rd_cached = rd_cached | stat_v[i].cached;
      rd_timer  = rd_timer | stat_v[i].timer;
      any_pass  = any_pass | stat_v[i].pass;
      any_exp   = any_exp | stat_v[i].expire;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    next_seq_nxt   = next_seq_r;
    base_nxt       = base_r;
    sent_nxt       = sent_r;
    acked_nxt      = acked_r;
    step_nxt       = step_r;
    act_nxt        = act_r;
    sseq_nxt       = sseq_r;
    pidx_nxt       = pidx_r;
    fresh_nxt      = fresh_r;
    ctl.op         = OP_NONE;
    ctl.tok        = TOK_HOLD;
    ctl.clr_cached = 1'b0;
    ctl.limit      = limit_r;
    tgt_idx        = base_r;
    ld_idx         = '0;
    rd_idx         = (cmd_r == CMD_TICK) ? base_r : next_seq_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        sseq_nxt  = '0;
        pidx_nxt  = '0;
        fresh_nxt = 1'b0;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_START: begin
            act_nxt      = ACT_NONE;
            ctl.op       = OP_CLEAR;
            ctl.tok      = TOK_CLR;
            next_seq_nxt = '0;
            base_nxt     = '0;
            sent_nxt     = '0;
            acked_nxt    = '0;
          end
          CMD_SEND: begin
            act_nxt = ACT_NONE;
            tgt_idx = next_seq_r;
            if (acked_r == total_r) begin
              act_nxt = ACT_END;
            end else if (next_in_win && rd_ack && (sent_r < total_r)) begin
              act_nxt      = ACT_DATA;
              sseq_nxt     = to5(next_seq_r);
              fresh_nxt    = ~rd_cached;
              pidx_nxt     = rd_cached ? 16'd0 : sent_r;
              ctl.op       = OP_SEND;
              next_seq_nxt = inc(next_seq_r);
              sent_nxt     = sent_inc;
            end
          end
          CMD_ACK: begin
            act_nxt = ACT_IGNORED;
            if (!kind_r) begin
              tgt_idx = base_r;
              if (aseq_r == 8'(base_r)) begin
                act_nxt        = ACT_TAKEN;
                ctl.op         = OP_ACK;
                ctl.clr_cached = 1'b1;
                base_nxt       = base_inc;
                acked_nxt      = acked_inc;
              end
            end else begin
              tgt_idx = aseq_idx;
              if (aseq_ok) begin
                act_nxt = ACT_TAKEN;
                ctl.op  = OP_ACK;
                if (aseq_idx == base_r) begin
                  ctl.clr_cached = 1'b1;
                  ctl.tok        = TOK_LOAD;
                  ld_idx         = base_inc;
                  base_nxt       = base_inc;
                  acked_nxt      = acked_inc;
                  step_nxt       = CNT_W'(1);
                  state_nxt      = S_SCAN;
                end
              end
            end
          end
          CMD_TICK: begin
            act_nxt = ACT_QUIET;
            if (!mode_r) begin
              tgt_idx = base_r;
              if (gbn_exp) begin
                act_nxt      = ACT_TIMEOUT;
                ctl.op       = OP_REWIND;
                sent_nxt     = (sent_r >= WIN16) ? sent_r - WIN16 : 16'd0;
                next_seq_nxt = base_r;
              end else begin
                ctl.op = OP_AGE;
              end
            end else begin
              ctl.tok   = TOK_LOAD;
              ld_idx    = '0;
              step_nxt  = '0;
              state_nxt = S_SWEEP;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if ((step_r < WIN_CNT) && any_pass) begin
          ctl.op    = OP_SCAN;
          ctl.tok   = TOK_SHIFT;
          base_nxt  = base_inc;
          acked_nxt = acked_inc;
          step_nxt  = step_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SWEEP: begin
        ctl.op   = OP_SWEEP;
        ctl.tok  = TOK_SHIFT;
        step_nxt = step_r + 1'b1;
        if (any_exp) begin
          act_nxt      = ACT_TIMEOUT;
          next_seq_nxt = base_r;
          sent_nxt     = sent_dec;
        end
        if (step_r == SWP_END) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_seq_r  <= '0;
      base_r      <= '0;
      sent_r      <= '0;
      acked_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      total_r     <= TOTAL_RST;
      limit_r     <= LIMIT_RST;
    end else begin
      state_r    <= state_nxt;
      next_seq_r <= next_seq_nxt;
      base_r     <= base_nxt;
      sent_r     <= sent_nxt;
      acked_r    <= acked_nxt;
      step_r     <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_MODE:  mode_r  <= pwdata[0];
          REG_TOTAL: total_r <= pwdata[15:0];
          REG_LIMIT: limit_r <= pwdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    sseq_r  <= sseq_nxt;
    pidx_r  <= pidx_nxt;
    fresh_r <= fresh_nxt;
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_cmd);
      kind_r <= in_ack_kind;
      aseq_r <= in_ack_seq;
    end
    if (out_load) begin
      o_act_r   <= act_r;
      o_sseq_r  <= sseq_r;
      o_pidx_r  <= pidx_r;
      o_fresh_r <= fresh_r;
      o_base_r  <= to5(base_r);
      o_acked_r <= acked_r;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = {31'd0, mode_r};
      REG_TOTAL: prdata = {16'd0, total_r};
      REG_LIMIT: prdata = {24'd0, limit_r};
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== tb/sv/arq_sender_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ARQ sender: tracks window state, predicts each result and compares.
module arq_sender_checker import arqsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_ack_kind,
  input  logic [7:0]  in_ack_seq,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_action,
  input  logic [4:0]  out_send_seq,
  input  logic [15:0] out_packet_index,
  input  logic        out_new_packet,
  input  logic [4:0]  out_base_seq,
  input  logic [15:0] out_acked_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output logic [4:0]  base_now
);

  localparam int unsigned SEQ_N = 20;
  localparam int unsigned WIN   = 10;
  localparam int unsigned SAT16 = 65535;

  typedef struct packed {
    action_t     action;
    logic [4:0]  send_seq;
    logic [15:0] packet_index;
    logic        new_packet;
    logic [4:0]  base_seq;
    logic [15:0] acked_total;
  } reply_t;

  logic        sr_mode;
  logic [15:0] total_pk;
  logic [7:0]  limit_reg;

  logic        ack_bit    [SEQ_N];
  logic        cached_bit [SEQ_N];
  logic [7:0]  timer      [SEQ_N];
  int unsigned next_slot;
  int unsigned win_base;
  int unsigned sent_cnt;
  int unsigned acked_cnt;

  reply_t      awaited_replies[$];

  function automatic void clear_session();
    for (int i = 0; i < SEQ_N; i++) begin
      ack_bit[i]    = 1'b1;
      cached_bit[i] = 1'b0;
      timer[i]      = '0;
    end
    next_slot = 0;
    win_base  = 0;
    sent_cnt  = 0;
    acked_cnt = 0;
  endfunction

  function automatic int unsigned win_offset(int unsigned seq);
    return (seq + SEQ_N - win_base) % SEQ_N;
  endfunction

  function automatic void bump_acked(int unsigned n);
    acked_cnt = acked_cnt + n;
    if (acked_cnt > SAT16) acked_cnt = SAT16;
  endfunction

  // 9-bit compare so a limit of 255 still expires
  function automatic logic age_timer(int unsigned idx);
    logic [8:0] t;
    t = {1'b0, timer[idx]} + 9'd1;
    if (t > {1'b0, limit_reg}) begin
      timer[idx] = '0;
      return 1'b1;
    end
    timer[idx] = (t > 9'd255) ? 8'hFF : t[7:0];
    return 1'b0;
  endfunction

  function automatic reply_t predict_reply(cmd_t c, logic kind, logic [7:0] aseq);
    reply_t      r;
    int unsigned i;
    int unsigned e;
    r = '0;
    r.action = ACT_NONE;
    case (c)
      CMD_START: clear_session();
      CMD_SEND: begin
        if (acked_cnt == total_pk) begin
          r.action = ACT_END;
        end else if (win_offset(next_slot) < WIN && ack_bit[next_slot] &&
                     sent_cnt < total_pk) begin
          r.action   = ACT_DATA;
          r.send_seq = next_slot[4:0];
          if (!cached_bit[next_slot]) begin
            r.new_packet          = 1'b1;
            r.packet_index        = sent_cnt[15:0];
            cached_bit[next_slot] = 1'b1;
          end
          ack_bit[next_slot] = 1'b0;
          next_slot = (next_slot + 1) % SEQ_N;
          if (sent_cnt < SAT16) sent_cnt++;
        end
      end
      CMD_ACK: begin
        r.action = ACT_IGNORED;
        if (!kind) begin
          if (aseq == win_base) begin
            timer[win_base]      = '0;
            ack_bit[win_base]    = 1'b1;
            cached_bit[win_base] = 1'b0;
            win_base = (win_base + 1) % SEQ_N;
            bump_acked(1);
            r.action = ACT_TAKEN;
          end
        end else if (aseq < SEQ_N && win_offset(aseq) < WIN) begin
          r.action     = ACT_TAKEN;
          ack_bit[aseq] = 1'b1;
          timer[aseq]   = '0;
          if (aseq == win_base) begin
            cached_bit[aseq] = 1'b0;
            i = 1;
            e = (win_base + 1) % SEQ_N;
            while (i < WIN && cached_bit[e] && ack_bit[e]) begin
              cached_bit[e] = 1'b0;
              i++;
              e = (win_base + i) % SEQ_N;
            end
            bump_acked(i);
            win_base = (win_base + i) % SEQ_N;
          end
        end
      end
      default: begin
        r.action = ACT_QUIET;
        if (!sr_mode) begin
          if (age_timer(win_base)) begin
            for (i = 0; i < WIN; i++) ack_bit[(win_base + i) % SEQ_N] = 1'b1;
            sent_cnt  = (sent_cnt >= WIN) ? sent_cnt - WIN : 0;
            next_slot = win_base;
            r.action  = ACT_TIMEOUT;
          end
        end else begin
          for (i = 0; i < SEQ_N; i++) begin
            if (!ack_bit[i]) begin
              if (age_timer(i)) begin
                ack_bit[i] = 1'b1;
                next_slot  = win_base;
                if (sent_cnt > 0) sent_cnt--;
                r.action = ACT_TIMEOUT;
              end
            end
          end
        end
      end
    endcase
    r.base_seq    = win_base[4:0];
    r.acked_total = acked_cnt[15:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      sr_mode    = 1'b0;
      total_pk   = TOTAL_RST;
      limit_reg  = LIMIT_RST;
      fail_count = 0;
      clear_session();
      awaited_replies.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:  sr_mode   = pwdata[0];
          REG_TOTAL: total_pk  = pwdata[15:0];
          REG_LIMIT: limit_reg = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        awaited_replies.push_back(predict_reply(cmd_t'(in_cmd), in_ack_kind, in_ack_seq));
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction, expected none, actual action %0d",
                   $time, out_action);
        end else begin
          want = awaited_replies.pop_front();
          check_field("action", 16'(want.action), 16'(out_action));
          check_field("send_seq", 16'(want.send_seq), 16'(out_send_seq));
          check_field("packet_index", want.packet_index, out_packet_index);
          check_field("new_packet", 16'(want.new_packet), 16'(out_new_packet));
          check_field("base_seq", 16'(want.base_seq), 16'(out_base_seq));
          check_field("acked_total", want.acked_total, out_acked_total);
        end
      end
    end
    pending  = awaited_replies.size();
    base_now = win_base[4:0];
  end

endmodule

// ===== tb/sv/tb_arq_sliding_window_sender.sv =====
`timescale 1ns / 1ps
// Testbench top for the ARQ sender: clock, reset, commands, config writes and verdict.
module tb_arq_sliding_window_sender;
  import arqsw_pkg::*;

  localparam int SEQ_SPAN   = 20;
  localparam int WIN_SPAN   = 10;
  localparam int SETTLE_CYC = 30;
  localparam int HOLD_CYC   = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic        in_ack_kind;
  logic [7:0]  in_ack_seq;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_action;
  logic [4:0]  out_send_seq;
  logic [15:0] out_packet_index;
  logic        out_new_packet;
  logic [4:0]  out_base_seq;
  logic [15:0] out_acked_total;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  logic [4:0]  base_now;
  logic        no_idle;
  logic        long_stall_req;
  logic        long_stall_done;

  arq_sliding_window_sender u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_ack_kind      (in_ack_kind),
    .in_ack_seq       (in_ack_seq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_send_seq     (out_send_seq),
    .out_packet_index (out_packet_index),
    .out_new_packet   (out_new_packet),
    .out_base_seq     (out_base_seq),
    .out_acked_total  (out_acked_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  arq_sender_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_ack_kind      (in_ack_kind),
    .in_ack_seq       (in_ack_seq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_send_seq     (out_send_seq),
    .out_packet_index (out_packet_index),
    .out_new_packet   (out_new_packet),
    .out_base_seq     (out_base_seq),
    .out_acked_total  (out_acked_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending),
    .base_now         (base_now)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  initial begin
    int g;
    out_ready       = 1'b0;
    long_stall_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_stall_req && !long_stall_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        long_stall_done = 1'b1;
        out_ready = 1'b1;
      end else begin
        g = idle_gap();
        if (g == 0) begin
          out_ready = 1'b1;
        end else begin
          out_ready = 1'b0;
          repeat (g) @(negedge clk);
          out_ready = 1'b1;
        end
      end
    end
  end

  task automatic offer(cmd_t c, logic k, logic [7:0] s);
    int g;
    in_valid    = 1'b1;
    in_cmd      = c;
    in_ack_kind = k;
    in_ack_seq  = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    g = idle_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // registers only change with the block drained
  task automatic configure(logic mode, logic [15:0] total, logic [7:0] limit);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    apb_write(REG_MODE, {31'b0, mode});
    apb_write(REG_TOTAL, {16'b0, total});
    apb_write(REG_LIMIT, {24'b0, limit});
  endtask

  task automatic random_phase(logic mode, logic [15:0] total, logic [7:0] limit, int n,
                              bit stall_mid);
    int         r;
    int         seq;
    cmd_t       c;
    logic       k;
    logic [7:0] s;
    configure(mode, total, limit);
    offer(CMD_START, 1'b0, 8'd0);
    for (int j = 0; j < n; j++) begin
      if (stall_mid && j == n / 3) long_stall_req = 1'b1;
      r = $urandom_range(0, 99);
      k = 1'($urandom_range(0, 1));
      s = 8'($urandom_range(0, 255));
      if (r < 4) begin
        c = CMD_START;
      end else if (r < 40) begin
        c = CMD_SEND;
      end else if (r < 75) begin
        c = CMD_ACK;
        k = ($urandom_range(0, 9) == 0) ? ~mode : mode;
        if ($urandom_range(0, 7) != 0) begin
          seq = k ? (int'(base_now) + $urandom_range(0, WIN_SPAN - 1)) % SEQ_SPAN
                  : int'(base_now);
          s = seq[7:0];
        end
      end else if (r < 92) begin
        c = CMD_TICK;
      end else begin
        c = CMD_ACK;
      end
      offer(c, k, s);
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_cmd         = CMD_START;
    in_ack_kind    = 1'b0;
    in_ack_seq     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    no_idle        = 1'b0;
    long_stall_req = 1'b0;
    rst_n          = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // go-back-n: fill, wrong ack, base ack, timeout and resend, end marker
    configure(1'b0, 16'd3, 8'd2);
    offer(CMD_START, 1'b0, 8'd0);
    repeat (4) offer(CMD_SEND, 1'b0, 8'd0);
    offer(CMD_ACK, 1'b0, 8'd5);
    offer(CMD_ACK, 1'b0, 8'd0);
    repeat (3) offer(CMD_TICK, 1'b0, 8'd0);
    offer(CMD_SEND, 1'b1, 8'hFF);
    offer(CMD_ACK, 1'b0, 8'd1);
    offer(CMD_ACK, 1'b0, 8'd2);
    offer(CMD_SEND, 1'b0, 8'd0);
    offer(CMD_ACK, 1'b1, 8'hFF);
    offer(CMD_TICK, 1'b1, 8'hAA);

    // selective repeat: out-of-order acks, base run advance, window edge, zero limit
    configure(1'b1, 16'hFFFF, 8'd0);
    offer(CMD_START, 1'b1, 8'h55);
    repeat (3) offer(CMD_SEND, 1'b0, 8'd0);
    offer(CMD_ACK, 1'b1, 8'd2);
    offer(CMD_ACK, 1'b1, 8'd1);
    offer(CMD_ACK, 1'b1, 8'd0);
    offer(CMD_ACK, 1'b1, 8'd15);
    offer(CMD_ACK, 1'b1, 8'd12);
    offer(CMD_SEND, 1'b0, 8'd0);
    offer(CMD_TICK, 1'b0, 8'd0);
    offer(CMD_ACK, 1'b0, 8'hFF);

    // limit 255 must still expire after 256 ticks
    configure(1'b0, 16'd2, 8'd255);
    no_idle = 1'b1;
    offer(CMD_START, 1'b0, 8'd0);
    offer(CMD_SEND, 1'b0, 8'd0);
    repeat (256) offer(CMD_TICK, 1'b0, 8'd0);
    offer(CMD_SEND, 1'b0, 8'd0);
    no_idle = 1'b0;

    random_phase(1'b0, 16'($urandom_range(3, 40)), 8'($urandom_range(1, 8)), 30, 1'b0);
    random_phase(1'b1, 16'd1, 8'd1, 15, 1'b0);
    random_phase(1'b1, 16'($urandom_range(5, 60)), 8'($urandom_range(1, 6)), 40, 1'b1);
    no_idle = 1'b1;
    random_phase(1'b0, 16'hFFFF, 8'd3, 20, 1'b0);
    no_idle = 1'b0;
    random_phase(1'($urandom_range(0, 1)), 16'($urandom_range(1, 30)),
                 8'($urandom_range(1, 10)), 25, 1'b0);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/arqsw_pkg.sv
hw/rtl/arqsw_cell.sv
hw/rtl/arq_sliding_window_sender.sv
tb/sv/arq_sender_checker.sv
tb/sv/tb_arq_sliding_window_sender.sv
